@@ hw/rtl/lsharp_pkg.sv @@
// Shared constants and types for the Laplacian sharpen block.
// Used by the stream interfaces and by laplacian_sharpen_3x3_rgb; depends on nothing.
package lsharp_pkg;

	// Pixel and channel layout: red is channel 0, green 1, blue 2.
	localparam int PIX_W   = 8;
	localparam int NUM_CH  = 3;
	localparam int PIX_MAX = 255;

	// Arithmetic widths. The difference 4c-n-s-w-e spans -1020..1020.
	localparam int DIFF_W    = 11;
	localparam int FORCE_W   = 12;
	localparam int FRAC_BITS = 8;
	localparam int PROD_W    = DIFF_W + FORCE_W + 1;
	localparam int SUM_W     = PROD_W - FRAC_BITS + 1;

	// Configuration registers.
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 12;
	localparam int MIN_DIM      = 3;
	localparam int DEFAULT_MAX_WIDTH = 1024;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET    = WIDTH_REG_W'(640);
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET   = HEIGHT_REG_W'(480);
	localparam logic [FORCE_W-1:0]      STRENGTH_RESET = FORCE_W'(256);

	// APB register map, one 32-bit word per register.
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 2;

	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH      = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT     = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_SHARPEN_STRENGTH = 2'd2;

	typedef logic [NUM_CH-1:0][PIX_W-1:0] rgb_t;
	typedef logic signed [DIFF_W-1:0]     diff_t;
	typedef logic signed [PROD_W-1:0]     prod_t;

	// Position information that travels with a pixel down the pipeline.
	typedef struct packed {
		logic emit;      // the pixel produces the sharpened result of the row above
		logic border;    // that result lies on the frame border
		logic last_row;  // the pixel sits on the last row and also produces a border pixel
		logic last_col;
	} pos_flags_t;

endpackage

@@ hw/rtl/lsharp_pix_in_if.sv @@
// Valid/ready channel carrying one raster RGB pixel into the sharpen block.
// Depends on lsharp_pkg for the channel width.
interface lsharp_pix_in_if;
	import lsharp_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] red_in;
	logic [PIX_W-1:0] green_in;
	logic [PIX_W-1:0] blue_in;

	modport source (output valid, output red_in, output green_in, output blue_in,
		input ready);
	modport sink (input valid, input red_in, input green_in, input blue_in,
		output ready);

endinterface

@@ hw/rtl/lsharp_pix_out_if.sv @@
// Valid/ready channel carrying one sharpened RGB pixel and its framing marks.
// Depends on lsharp_pkg for the channel width.
interface lsharp_pix_out_if;
	import lsharp_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] red_out;
	logic [PIX_W-1:0] green_out;
	logic [PIX_W-1:0] blue_out;
	logic             last_of_run;
	logic             frame_end;

	modport source (output valid, output red_out, output green_out, output blue_out,
		output last_of_run, output frame_end, input ready);
	modport sink (input valid, input red_out, input green_out, input blue_out,
		input last_of_run, input frame_end, output ready);

endinterface

@@ hw/rtl/laplacian_sharpen_3x3_rgb.sv @@
// Streaming cross-shaped 3x3 sharpen of an RGB frame in raster order. Each channel becomes
// clip(c + floor(f*(4c - n - s - w - e))) with f the unsigned Q4.8 force; border pixels
// come out as zero and results lag the input by one row. The block accepts one pixel per
// clock while the output is not stalled; on the last row of a frame every pixel yields two
// results through the single output register, so there the pipeline stalls while the first
// of the two is shown. The row stores are read at the edge that accepts a request; the
// difference, one multiplier per channel, and flooring with clipping into the output
// register follow as registered stages that can each stall. Two row stores of MAX_WIDTH x
// 24 bits with a registered read hold the two previous rows; the newer one is read at the
// centre and east columns in the same cycle. The stores are not cleared, so the first two
// rows of the first frame must be complete before the results use them.
// Depends on lsharp_pkg and the two stream interfaces.
module laplacian_sharpen_3x3_rgb #(
	parameter int MAX_WIDTH = lsharp_pkg::DEFAULT_MAX_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lsharp_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [lsharp_pkg::APB_DATA_W-1:0] pwdata,
	output logic [lsharp_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	lsharp_pix_in_if.sink                   pixels,
	lsharp_pix_out_if.source                sharpened
);
	import lsharp_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int ZW = ((AW + 1) > WIDTH_REG_W ? (AW + 1) : WIDTH_REG_W) + 1;
	localparam int RW = HEIGHT_REG_W + 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(MAX_WIDTH - 1);

	// Configuration registers.
	logic [WIDTH_REG_W-1:0]  image_width_q;
	logic [HEIGHT_REG_W-1:0] image_height_q;
	logic [FORCE_W-1:0]      strength_q;
	logic                    cfg_write;
	logic [REG_IDX_W-1:0]    reg_idx;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[REG_IDX_W+1:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RESET;
			image_height_q <= HEIGHT_RESET;
			strength_q     <= STRENGTH_RESET;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_IMAGE_WIDTH:      image_width_q  <= pwdata[WIDTH_REG_W-1:0];
				REG_IMAGE_HEIGHT:     image_height_q <= pwdata[HEIGHT_REG_W-1:0];
				REG_SHARPEN_STRENGTH: strength_q     <= pwdata[FORCE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_IMAGE_WIDTH:      prdata = APB_DATA_W'(image_width_q);
			REG_IMAGE_HEIGHT:     prdata = APB_DATA_W'(image_height_q);
			REG_SHARPEN_STRENGTH: prdata = APB_DATA_W'(strength_q);
			default:              prdata = '0;
		endcase
	end

	// Pipeline handshake.
	logic in_fire;
	logic valid_s1, valid_s2, valid_s3, out_valid_q, second_q;
	logic out_free, s3_free, s2_free, s1_free, s1_adv;
	logic show_pix, out_done;
	pos_flags_t out_flags_q;

	// While the first of two results is shown the output register does not free up.
	assign show_pix = out_flags_q.emit && !second_q;
	assign out_done = out_valid_q && sharpened.ready && !(show_pix && out_flags_q.last_row);
	assign out_free = !out_valid_q || out_done;
	assign s3_free  = !valid_s3 || out_free;
	assign s2_free  = !valid_s2 || s3_free;
	assign s1_free  = !valid_s1 || s2_free;
	assign s1_adv   = valid_s1 && s2_free;

	assign pixels.ready = s1_free;
	assign in_fire      = pixels.valid && s1_free;

	// Position counters and the flags of the incoming pixel.
	logic [AW-1:0]           col_q;
	logic [HEIGHT_REG_W-1:0] row_q;
	logic [ZW-1:0]           w_eff;
	logic [RW-1:0]           h_eff;
	logic [RW-1:0]           row_ext;
	logic                    last_col, last_row;
	logic                    east_zero;
	logic [AW-1:0]           east_idx;
	pos_flags_t              flags_in;

	always_comb begin
		w_eff = ZW'(image_width_q);
		if (w_eff < ZW'(MIN_DIM)) begin
			w_eff = ZW'(MIN_DIM);
		end else if (w_eff > ZW'(MAX_WIDTH)) begin
			w_eff = ZW'(MAX_WIDTH);
		end
		h_eff = RW'(image_height_q);
		if (h_eff < RW'(MIN_DIM)) begin
			h_eff = RW'(MIN_DIM);
		end
		row_ext  = RW'(row_q);
		last_col = (ZW'(col_q) + ZW'(1)) >= w_eff;
		last_row = (row_ext + RW'(1)) >= h_eff;

		flags_in.emit     = (row_q != '0);
		flags_in.border   = (row_q == HEIGHT_REG_W'(1)) || (col_q == '0) || last_col
			|| (row_ext >= h_eff);
		flags_in.last_row = last_row;
		flags_in.last_col = last_col;

		east_zero = (col_q == LAST_IDX);
		east_idx  = east_zero ? col_q : col_q + AW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + HEIGHT_REG_W'(1);
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	// Row stores. Reads are issued with the request; the write-back happens when the
	// pixel leaves stage 1. With at least three columns the next request never reads
	// the column being written, so no forwarding is needed.
	rgb_t row_store_newer_q [MAX_WIDTH];
	rgb_t row_store_older_q [MAX_WIDTH];
	rgb_t centre_rd_q, east_rd_q, north_rd_q;
	rgb_t cur_s1;
	logic [AW-1:0] col_s1;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			centre_rd_q <= row_store_newer_q[col_q];
			east_rd_q   <= row_store_newer_q[east_idx];
		end
		if (s1_adv) begin
			row_store_newer_q[col_s1] <= cur_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			north_rd_q <= row_store_older_q[col_q];
		end
		if (s1_adv) begin
			row_store_older_q[col_s1] <= centre_rd_q;
		end
	end

	// Stage 1: neighborhood and Laplacian difference.
	pos_flags_t flags_s1, flags_s2, flags_s3;
	logic       east_zero_s1;
	rgb_t       west_q;
	rgb_t       east_px;
	diff_t      diff_d [NUM_CH];

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cur_s1       <= {pixels.blue_in, pixels.green_in, pixels.red_in};
			col_s1       <= col_q;
			flags_s1     <= flags_in;
			east_zero_s1 <= east_zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			west_q <= '0;
		end else if (s1_adv) begin
			west_q <= centre_rd_q;
		end
	end

	always_comb begin
		east_px = east_zero_s1 ? '0 : east_rd_q;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			diff_d[ch] = diff_t'(DIFF_W'({centre_rd_q[ch], 2'b00}) - DIFF_W'(north_rd_q[ch])
				- DIFF_W'(cur_s1[ch]) - DIFF_W'(west_q[ch]) - DIFF_W'(east_px[ch]));
		end
	end

	// Stage 2: one multiplier per channel.
	diff_t diff_s2 [NUM_CH];
	rgb_t  cpix_s2;
	prod_t prod_d [NUM_CH];

	always_ff @(posedge clk) begin
		if (s2_free) begin
			diff_s2  <= diff_d;
			cpix_s2  <= centre_rd_q;
			flags_s2 <= flags_s1;
		end
	end

	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			prod_d[ch] = PROD_W'(diff_s2[ch]) * PROD_W'($signed({1'b0, strength_q}));
		end
	end

	// Stage 3: floor by the fraction bits, add the centre and clip.
	prod_t prod_s3 [NUM_CH];
	rgb_t  cpix_s3;
	rgb_t  pix_d;
	logic signed [PROD_W-FRAC_BITS-1:0] corr;
	logic signed [SUM_W-1:0]            sum;

	always_ff @(posedge clk) begin
		if (s3_free) begin
			prod_s3  <= prod_d;
			cpix_s3  <= cpix_s2;
			flags_s3 <= flags_s2;
		end
	end

	always_comb begin
		pix_d = '0;
		corr  = '0;
		sum   = '0;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			corr = prod_s3[ch][PROD_W-1:FRAC_BITS];
			sum  = $signed({{(SUM_W-PIX_W){1'b0}}, cpix_s3[ch]}) + SUM_W'(corr);
			if (flags_s3.border || sum[SUM_W-1] || (sum == '0)) begin
				pix_d[ch] = '0;
			end else if (sum >= SUM_W'(PIX_MAX)) begin
				pix_d[ch] = PIX_W'(PIX_MAX);
			end else begin
				pix_d[ch] = sum[PIX_W-1:0];
			end
		end
	end

	// Output register; a last-row pixel shows its sharpened result first, then the
	// zero border pixel of its own row.
	rgb_t out_pix_q;

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_pix_q   <= pix_d;
			out_flags_q <= flags_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= in_fire;
			end
			// Pixels of the first row produce nothing and end after their write-back.
			if (s2_free) begin
				valid_s2 <= valid_s1 && (flags_s1.emit || flags_s1.last_row);
			end
			if (s3_free) begin
				valid_s3 <= valid_s2;
			end
			if (out_free) begin
				out_valid_q <= valid_s3;
				second_q    <= 1'b0;
			end else if (sharpened.ready && show_pix && out_flags_q.last_row) begin
				second_q <= 1'b1;
			end
		end
	end

	assign sharpened.valid       = out_valid_q;
	assign sharpened.red_out     = show_pix ? out_pix_q[0] : '0;
	assign sharpened.green_out   = show_pix ? out_pix_q[1] : '0;
	assign sharpened.blue_out    = show_pix ? out_pix_q[2] : '0;
	assign sharpened.last_of_run = show_pix ? !out_flags_q.last_row : 1'b1;
	assign sharpened.frame_end   = show_pix ? 1'b0 : out_flags_q.last_col;

endmodule
